### hw/rtl/led_command_line_parser_macros.svh
// Assertion macros shared by the parser modules.
`ifndef LED_COMMAND_LINE_PARSER_MACROS_SVH
`define LED_COMMAND_LINE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define LCP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("Parser check failed.");
`define LCP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Parser check failed.");
`else
`define LCP_ASSERT(label, clk, rst, prop)
`define LCP_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/lcp_pkg.sv
package lcp_pkg;

   localparam int LineCapacityDefault = 64;
   localparam int LevelWidth = 7;

   localparam logic [7:0] CharNul       = 8'h00;
   localparam logic [7:0] CharTab       = 8'h09;
   localparam logic [7:0] CharLf        = 8'h0A;
   localparam logic [7:0] CharVtab      = 8'h0B;
   localparam logic [7:0] CharFormFeed  = 8'h0C;
   localparam logic [7:0] CharCr        = 8'h0D;
   localparam logic [7:0] CharSpace     = 8'h20;
   localparam logic [7:0] CharPlus      = 8'h2B;
   localparam logic [7:0] CharMinus     = 8'h2D;
   localparam logic [7:0] CharZero      = 8'h30;
   localparam logic [7:0] CharNine      = 8'h39;
   localparam logic [7:0] CharColon     = 8'h3A;
   localparam logic [7:0] CharUpperL    = 8'h4C;
   localparam logic [7:0] CharUpperE    = 8'h45;
   localparam logic [7:0] CharUpperD    = 8'h44;
   localparam logic [LevelWidth-1:0] LevelMax = 7'd100;

   typedef enum logic [2:0] {
      NAME_START,
      NAME_L,
      NAME_LE,
      NAME_LED,
      NAME_MISS
   } name_phase_type;

   typedef enum logic [1:0] {
      NUM_BLANKS,
      NUM_DIGITS,
      NUM_DONE
   } number_phase_type;

   typedef struct packed {
      logic                  valid;
      logic [LevelWidth-1:0] level;
   } result_type;

endpackage

### hw/rtl/led_command_line_parser.sv
// LED command line parser. Received characters arrive one per request on
// req_tdata and are gathered into lines ended by LF or CR; a line of the form
// "LED:<number>" yields one response carrying the level clamped to 0..100.
// A new request is accepted in every cycle while the output buffer is not full;
// the line state is updated in a single pass, and a two-entry output
// buffer keeps the request side running while a response waits to be taken.
// With the output buffer empty, a response appears on rsp_tvalid in the cycle after its line end is accepted.
module led_command_line_parser #(
   parameter int LINE_CAPACITY = lcp_pkg::LineCapacityDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [6:0] led_level, [7] zero
);
   import lcp_pkg::*;

   result_type            result;
   logic                  take;
   logic [LevelWidth-1:0] level;

   assign take      = req_tvalid && req_tready;
   assign rsp_tdata = {1'b0, level};

   lcp_parser #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_char (req_tdata),
      .result  (result)
   );

   lcp_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_level (level)
   );

endmodule

### hw/rtl/lcp_parser.sv
module lcp_parser #(
   parameter int LINE_CAPACITY = lcp_pkg::LineCapacityDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         rx_char,
   output lcp_pkg::result_type result
);
   import lcp_pkg::*;
`include "led_command_line_parser_macros.svh"

   localparam int CountWidth = $clog2(LINE_CAPACITY);
   localparam logic [CountWidth-1:0] LastCount = CountWidth'(LINE_CAPACITY - 1);

   logic [CountWidth-1:0] line_count_ff, line_count_in;
   name_phase_type        name_phase_ff, name_phase_in;
   logic                  colon_seen_ff, colon_seen_in;
   number_phase_type      number_phase_ff, number_phase_in;
   logic                  negative_sign_ff, negative_sign_in;
   logic [LevelWidth-1:0] number_value_ff, number_value_in;
   logic                  text_ended_ff, text_ended_in;

   logic                  is_digit;
   logic                  add_digit;
   logic [10:0]           scaled;

   assign is_digit = (rx_char >= CharZero) && (rx_char <= CharNine);
   assign scaled = 11'(number_value_ff) * 11'd10 + 11'(rx_char[3:0]);

   always_comb begin
      line_count_in    = line_count_ff;
      name_phase_in    = name_phase_ff;
      colon_seen_in    = colon_seen_ff;
      number_phase_in  = number_phase_ff;
      negative_sign_in = negative_sign_ff;
      number_value_in  = number_value_ff;
      text_ended_in    = text_ended_ff;
      add_digit        = 1'b0;
      result.valid     = 1'b0;
      result.level     = negative_sign_ff ? '0 : number_value_ff;

      if (take) begin
         if (rx_char == CharLf || rx_char == CharCr) begin
            if (line_count_ff != '0) begin
               result.valid     = colon_seen_ff && (name_phase_ff == NAME_LED);
               line_count_in    = '0;
               name_phase_in    = NAME_START;
               colon_seen_in    = 1'b0;
               number_phase_in  = NUM_BLANKS;
               negative_sign_in = 1'b0;
               number_value_in  = '0;
               text_ended_in    = 1'b0;
            end
         end else if (line_count_ff < LastCount) begin
            line_count_in = line_count_ff + 1'b1;
            if (!text_ended_ff) begin
               if (rx_char == CharNul) begin
                  text_ended_in = 1'b1;
               end else if (colon_seen_ff) begin
                  case (number_phase_ff)
                     NUM_BLANKS: begin
                        if (rx_char inside {CharSpace, CharTab, CharVtab, CharFormFeed}) begin
                           number_phase_in = NUM_BLANKS;
                        end else if (rx_char == CharPlus || rx_char == CharMinus) begin
                           negative_sign_in = (rx_char == CharMinus);
                           number_phase_in  = NUM_DIGITS;
                        end else if (is_digit) begin
                           number_phase_in = NUM_DIGITS;
                           add_digit       = 1'b1;
                        end else begin
                           number_phase_in = NUM_DONE;
                        end
                     end
                     NUM_DIGITS: begin
                        if (is_digit) begin
                           add_digit = 1'b1;
                        end else begin
                           number_phase_in = NUM_DONE;
                        end
                     end
                     default: begin
                        number_phase_in = NUM_DONE;
                     end
                  endcase
               end else if (rx_char == CharColon) begin
                  colon_seen_in = 1'b1;
                  if (name_phase_ff != NAME_LED) begin
                     name_phase_in = NAME_MISS;
                  end
               end else if (name_phase_ff == NAME_START && rx_char == CharUpperL) begin
                  name_phase_in = NAME_L;
               end else if (name_phase_ff == NAME_L && rx_char == CharUpperE) begin
                  name_phase_in = NAME_LE;
               end else if (name_phase_ff == NAME_LE && rx_char == CharUpperD) begin
                  name_phase_in = NAME_LED;
               end else begin
                  name_phase_in = NAME_MISS;
               end
            end
            if (add_digit) begin
               number_value_in = (scaled > 11'(LevelMax)) ? LevelMax : scaled[LevelWidth-1:0];
            end
         end else begin
            line_count_in    = '0;
            name_phase_in    = NAME_START;
            colon_seen_in    = 1'b0;
            number_phase_in  = NUM_BLANKS;
            negative_sign_in = 1'b0;
            number_value_in  = '0;
            text_ended_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff    <= '0;
         name_phase_ff    <= NAME_START;
         colon_seen_ff    <= 1'b0;
         number_phase_ff  <= NUM_BLANKS;
         negative_sign_ff <= 1'b0;
         number_value_ff  <= '0;
         text_ended_ff    <= 1'b0;
      end else begin
         line_count_ff    <= line_count_in;
         name_phase_ff    <= name_phase_in;
         colon_seen_ff    <= colon_seen_in;
         number_phase_ff  <= number_phase_in;
         negative_sign_ff <= negative_sign_in;
         number_value_ff  <= number_value_in;
         text_ended_ff    <= text_ended_in;
      end
   end

   `LCP_ASSERT(a_count_below_capacity, clock, reset, line_count_ff <= LastCount)
   `LCP_ASSERT(a_value_saturated, clock, reset, number_value_ff <= LevelMax)
   `LCP_ASSERT_IMPL(a_colon_before_number, clock, reset, number_phase_ff != NUM_BLANKS, colon_seen_ff)
   `LCP_ASSERT_IMPL(a_empty_line_clean, clock, reset, line_count_ff == '0, !colon_seen_ff && name_phase_ff == NAME_START)

endmodule

### hw/rtl/lcp_out_buffer.sv
module lcp_out_buffer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lcp_pkg::result_type                  result,
   output logic                                 in_ready,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [lcp_pkg::LevelWidth-1:0]       out_level
);
   import lcp_pkg::*;
`include "led_command_line_parser_macros.svh"

   logic [LevelWidth-1:0] slot_ff [2];
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push;
   logic                  pop;
   logic                  wr_ptr;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_level = slot_ff[rd_ptr_ff];
   assign push      = result.valid;
   assign pop       = out_valid && out_ready;
   assign wr_ptr    = rd_ptr_ff ^ count_ff[0];

   always_comb begin
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr] <= result.level;
      end
   end

   `LCP_ASSERT(a_count_bound, clock, reset, count_ff <= 2'd2)
   `LCP_ASSERT_IMPL(a_no_push_when_full, clock, reset, count_ff == 2'd2, !push)

endmodule

### tb/sv/tb_led_command_line_parser.sv
module tb_led_command_line_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import lcp_pkg::*;

   localparam int LineCapacity = LineCapacityDefault;
   localparam int RandomChars = 1700;
   localparam int CycleLimit = 400000;
   localparam logic [7:0] TableNul = "@";

   typedef enum {
      CHECK_PREDICTED,
      CHECK_LEVEL,
      CHECK_SILENT
   } line_check_type;

   typedef struct {
      string                 text;
      line_check_type        check;
      logic [LevelWidth-1:0] level;
   } directed_line_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] rx_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [6:0] led_level, [7] zero

   logic [LevelWidth-1:0] led_levels_due[$];
   logic [LevelWidth-1:0] due_level;
   int unsigned           failures = 0;
   int unsigned           cycle_count = 0;
   int unsigned           random_chars_sent = 0;
   int unsigned           sender_idle_pct = 0;
   int unsigned           receiver_idle_pct = 0;

   int unsigned           held_chars;
   name_phase_type        name_st;
   logic                  colon_found;
   number_phase_type      num_st;
   logic                  minus_taken;
   logic [LevelWidth-1:0] magnitude;
   logic                  nul_seen;

   logic [7:0] blank_chars[4] = '{CharSpace, CharTab, CharVtab, CharFormFeed};

   // An at sign in a line of this table stands for a zero byte.
   directed_line_type directed_lines[] = '{
      '{"\n", CHECK_SILENT, 7'd0},
      '{"LED:0\n", CHECK_LEVEL, 7'd0},
      '{"LED:100\n", CHECK_LEVEL, 7'd100},
      '{"LED:101\n", CHECK_LEVEL, 7'd100},
      '{"LED:99999999\n", CHECK_LEVEL, 7'd100},
      '{"LED:-5\r", CHECK_LEVEL, 7'd0},
      '{"LED:-0\n", CHECK_LEVEL, 7'd0},
      '{"LED: \t\013\014+42x7\n", CHECK_LEVEL, 7'd42},
      '{"LED:\n", CHECK_LEVEL, 7'd0},
      '{"LED:abc\n", CHECK_LEVEL, 7'd0},
      '{"LED\n", CHECK_SILENT, 7'd0},
      '{"LEDX:5\n", CHECK_SILENT, 7'd0},
      '{"led:5\n", CHECK_SILENT, 7'd0},
      '{":5\n", CHECK_SILENT, 7'd0},
      '{"LE@D:5\n", CHECK_SILENT, 7'd0},
      '{"LED:7@3\n", CHECK_LEVEL, 7'd7},
      '{"LED:1:2\n", CHECK_LEVEL, 7'd1},
      '{"LED:\377\n", CHECK_LEVEL, 7'd0},
      '{"\r\r\n", CHECK_SILENT, 7'd0},
      '{"LED: +63 %\r", CHECK_PREDICTED, 7'd0},
      '{"xLED:9\nLED:88\n", CHECK_PREDICTED, 7'd0}
   };

   led_command_line_parser #(
      .LINE_CAPACITY(LineCapacity)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void clear_line();
      held_chars = 0;
      name_st = NAME_START;
      colon_found = 1'b0;
      num_st = NUM_BLANKS;
      minus_taken = 1'b0;
      magnitude = '0;
      nul_seen = 1'b0;
   endfunction

   function automatic bit parse_rx_byte(input logic [7:0] ch,
                                        output logic [LevelWidth-1:0] level);
      int unsigned scaled;
      bit is_digit;
      bit is_blank;
      parse_rx_byte = 1'b0;
      level = '0;
      is_digit = (ch >= CharZero) && (ch <= CharNine);
      is_blank = (ch == CharSpace) || (ch == CharTab) || (ch == CharVtab) ||
                 (ch == CharFormFeed);
      if (ch == CharLf || ch == CharCr) begin
         if (held_chars != 0) begin
            if (colon_found && name_st == NAME_LED) begin
               parse_rx_byte = 1'b1;
               level = minus_taken ? '0 : magnitude;
            end
            clear_line();
         end
      end else if (held_chars >= LineCapacity - 1) begin
         clear_line();
      end else begin
         held_chars++;
         if (!nul_seen) begin
            if (ch == CharNul) begin
               nul_seen = 1'b1;
            end else if (colon_found) begin
               if (num_st == NUM_BLANKS && is_blank) begin
                  num_st = NUM_BLANKS;
               end else if (num_st == NUM_BLANKS && (ch == CharPlus || ch == CharMinus)) begin
                  minus_taken = (ch == CharMinus);
                  num_st = NUM_DIGITS;
               end else if (is_digit && num_st != NUM_DONE) begin
                  num_st = NUM_DIGITS;
                  scaled = magnitude * 10 + (ch - CharZero);
                  magnitude = (scaled > LevelMax) ? LevelMax : scaled[LevelWidth-1:0];
               end else begin
                  num_st = NUM_DONE;
               end
            end else if (ch == CharColon) begin
               colon_found = 1'b1;
               if (name_st != NAME_LED) begin
                  name_st = NAME_MISS;
               end
            end else if (name_st == NAME_START && ch == CharUpperL) begin
               name_st = NAME_L;
            end else if (name_st == NAME_L && ch == CharUpperE) begin
               name_st = NAME_LE;
            end else if (name_st == NAME_LE && ch == CharUpperD) begin
               name_st = NAME_LED;
            end else begin
               name_st = NAME_MISS;
            end
         end
      end
   endfunction

   function automatic logic [7:0] random_text_char();
      logic [7:0] ch;
      do begin
         ch = 8'($urandom_range(255));
      end while (ch == CharLf || ch == CharCr);
      return ch;
   endfunction

   task automatic drive_request(input logic [7:0] ch);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_predicted(input logic [7:0] ch);
      logic [LevelWidth-1:0] level;
      if (parse_rx_byte(ch, level)) begin
         led_levels_due.push_back(level);
      end
      drive_request(ch);
      random_chars_sent++;
   endtask

   task automatic send_random_line();
      logic [7:0] line[$];
      int unsigned shape;
      int unsigned sign_pick;
      shape = $urandom_range(99);
      if (shape < 8) begin
         repeat ($urandom_range(LineCapacity - 4, LineCapacity + 2)) begin
            line.push_back(random_text_char());
         end
      end
      if (shape < 70) begin
         line.push_back(CharUpperL);
         line.push_back(CharUpperE);
         line.push_back(CharUpperD);
         line.push_back(CharColon);
         if ($urandom_range(9) == 0) begin
            line[line.size() - 1 - $urandom_range(3)] = random_text_char();
         end
         repeat ($urandom_range(0, 2)) line.push_back(blank_chars[$urandom_range(3)]);
         sign_pick = $urandom_range(3);
         if (sign_pick == 0) begin
            line.push_back(CharPlus);
         end else if (sign_pick == 1) begin
            line.push_back(CharMinus);
         end
         repeat ($urandom_range(0, 4)) line.push_back(8'(CharZero + $urandom_range(9)));
         if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) line.push_back(random_text_char());
         end
      end else if (shape < 80) begin
         repeat ($urandom_range(40, 2 * LineCapacity + 10)) line.push_back(random_text_char());
      end else if (shape < 90) begin
         repeat ($urandom_range(0, 10)) line.push_back(8'($urandom_range(255)));
      end
      line.push_back($urandom_range(1) ? CharLf : CharCr);
      foreach (line[i]) begin
         send_predicted(line[i]);
      end
   endtask

   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (led_levels_due.size() != 0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (led_levels_due.size() == 0) begin
               $error("unexpected led_level response: actual %0d", rsp_tdata[LevelWidth-1:0]);
               failures++;
            end else begin
               due_level = led_levels_due.pop_front();
               if (rsp_tdata[LevelWidth-1:0] !== due_level) begin
                  $error("led_level: expected %0d, actual %0d", due_level,
                         rsp_tdata[LevelWidth-1:0]);
                  failures++;
               end
               if (rsp_tdata[7] !== 1'b0) begin
                  $error("rsp_tdata[7]: expected 0, actual %b", rsp_tdata[7]);
                  failures++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("tb_led_command_line_parser failed");
         $finish;
      end
   end

   initial begin
      logic [LevelWidth-1:0] level;
      logic [7:0]            ch;
      bit                    produced;
      string                 row_text;
      clear_line();
      sender_idle_pct = 6;
      receiver_idle_pct = 63;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_lines[r]) begin
         row_text = directed_lines[r].text;
         for (int i = 0; i < row_text.len(); i++) begin
            ch = (row_text[i] == TableNul) ? CharNul : row_text[i];
            produced = parse_rx_byte(ch, level);
            if (i == row_text.len() - 1 && directed_lines[r].check != CHECK_PREDICTED) begin
               if (directed_lines[r].check == CHECK_LEVEL) begin
                  led_levels_due.push_back(directed_lines[r].level);
               end
            end else if (produced) begin
               led_levels_due.push_back(level);
            end
            drive_request(ch);
         end
      end

      while (random_chars_sent < RandomChars / 3) send_random_line();
      wait_for_responses();

      sender_idle_pct = 63;
      receiver_idle_pct = 6;
      while (random_chars_sent < 2 * RandomChars / 3) send_random_line();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      while (random_chars_sent < RandomChars) send_random_line();

      wait_for_responses();
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("tb_led_command_line_parser passed");
      end else begin
         $display("tb_led_command_line_parser failed");
      end
      $finish;
   end

endmodule

### led_command_line_parser.f
+incdir+hw/rtl
hw/rtl/lcp_pkg.sv
hw/rtl/lcp_parser.sv
hw/rtl/lcp_out_buffer.sv
hw/rtl/led_command_line_parser.sv
tb/sv/tb_led_command_line_parser.sv
